@@ design/dfk_pkg.sv @@
// Shared types, constants and helpers for the delta forward kinematics block.
`default_nettype none

package dfk_pkg;

   localparam int POS_W       = 27;   // positions, heights, effector coordinates
   localparam int ARM_W       = 26;   // rod length
   localparam int DIFF_W      = POS_W + 1;
   localparam int MUL_W       = 32;   // multiplier operand width
   localparam int ACC_W       = 64;   // products and sums
   localparam int UNIT_BITS   = 30;   // fraction bits of the unit axes
   localparam int PROJ_W      = 30;
   localparam int DIST_W      = 28;
   localparam int VLEN_W      = 30;
   localparam int STEP_W      = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;
   localparam int REQ_TDATA_W = ((3 * POS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((3 * POS_W + 7) / 8) * 8;

   localparam logic signed [ACC_W-1:0] HALF_UNIT = 64'sd1 <<< (UNIT_BITS - 1);
   localparam logic signed [ACC_W-1:0] POS_MAX   = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
   localparam logic signed [ACC_W-1:0] POS_MIN   = -(64'sd1 <<< (POS_W - 1));

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_UNREACHABLE = 2'd1,
      ST_DEGENERATE  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_TOWER_A_X  = 3'd0,
      REG_TOWER_A_Y  = 3'd1,
      REG_TOWER_B_X  = 3'd2,
      REG_TOWER_B_Y  = 3'd3,
      REG_TOWER_C_X  = 3'd4,
      REG_TOWER_C_Y  = 3'd5,
      REG_ARM_LENGTH = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_DSQ, BK_SQ_DIST, BK_UDIV, BK_PROJ, BK_VRAW, BK_VSQ, BK_SQ_VLEN,
      BK_VDIV, BK_CROSS, BK_NUM, BK_YDIV, BK_ZSQ, BK_SQ_Z, BK_RES, BK_DONE
   } back_state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] a_x;
      logic signed [POS_W-1:0] a_y;
      logic signed [POS_W-1:0] b_x;
      logic signed [POS_W-1:0] b_y;
      logic signed [POS_W-1:0] c_x;
      logic signed [POS_W-1:0] c_y;
      logic        [ARM_W-1:0] arm;
   } geom_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] ab_x;
      logic signed [DIFF_W-1:0] ab_y;
      logic signed [DIFF_W-1:0] ab_z;
      logic signed [DIFF_W-1:0] ac_x;
      logic signed [DIFF_W-1:0] ac_y;
      logic signed [DIFF_W-1:0] ac_z;
      logic signed [POS_W-1:0]  height_a;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      status_type              status;
   } result_type;

   // round half up, then drop the unit fraction bits
   function automatic logic signed [ACC_W-1:0] rnd_unit(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + HALF_UNIT;
      return t >>> UNIT_BITS;
   endfunction

endpackage

`default_nettype wire

@@ design/dfk_front.sv @@
// Front end: takes carriage heights, forms the tower-to-tower vectors, queues items.
`default_nettype none

module dfk_front
   import dfk_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  geom_type                geom,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [POS_W-1:0] carriage_a,
   input  logic signed [POS_W-1:0] carriage_b,
   input  logic signed [POS_W-1:0] carriage_c,
   output link_type                q_link,
   input  logic                    q_ready
);

   item_type            mem_ff [QUEUE_DEPTH];
   item_type            item_in;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push, pop;

   always_comb begin
      item_in.ab_x     = DIFF_W'(geom.b_x) - DIFF_W'(geom.a_x);
      item_in.ab_y     = DIFF_W'(geom.b_y) - DIFF_W'(geom.a_y);
      item_in.ab_z     = DIFF_W'(carriage_b) - DIFF_W'(carriage_a);
      item_in.ac_x     = DIFF_W'(geom.c_x) - DIFF_W'(geom.a_x);
      item_in.ac_y     = DIFF_W'(geom.c_y) - DIFF_W'(geom.a_y);
      item_in.ac_z     = DIFF_W'(carriage_c) - DIFF_W'(carriage_a);
      item_in.height_a = carriage_a;
   end

   assign req_ready    = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push         = req_valid && req_ready;
   assign q_link.valid = (count_ff != '0);
   assign q_link.item  = mem_ff[rd_ptr_ff];
   assign pop          = q_link.valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ design/dfk_div.sv @@
// Signed-by-positive divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module dfk_div
   import dfk_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] dividend,
   input  logic [MUL_W-1:0]        divisor,
   output logic                    done,
   output logic signed [ACC_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ACC_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] num_ff, num_in;
   logic [MUL_W-1:0] rem_ff, rem_in;
   logic [MUL_W-1:0] den_ff, den_in;
   logic [MUL_W:0]   rem_sh;
   logic [MUL_W+1:0] diff;

   assign rem_sh = {rem_ff, num_ff[ACC_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      neg_in   = neg_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(ACC_W - 1);
         neg_in   = dividend[ACC_W-1];
         num_in   = dividend[ACC_W-1] ? unsigned'(-dividend) : unsigned'(dividend);
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[MUL_W+1]) begin
            rem_in = diff[MUL_W-1:0];
            num_in = {num_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[MUL_W-1:0];
            num_in = {num_ff[ACC_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(num_ff) : $signed(num_ff);

endmodule

`default_nettype wire

@@ design/dfk_sqrt.sv @@
// Integer square root (floor), two radicand bits per cycle.
`default_nettype none

module dfk_sqrt
   import dfk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ACC_W-1:0] operand,
   output logic             done,
   output logic [MUL_W-1:0] root
);

   localparam int CNT_W = $clog2(MUL_W);
   localparam int REM_W = MUL_W + 2;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ACC_W-1:0] x_ff, x_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [MUL_W-1:0] root_ff, root_in;
   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;

   assign rem_sh = {rem_ff, x_ff[ACC_W-1:ACC_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(MUL_W - 1);
         x_in     = operand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         x_in = {x_ff[ACC_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[MUL_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[MUL_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      x_ff     <= x_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ design/dfk_back.sv @@
// Back end: sequences the trilateration on one multiplier, the divider and the root unit.
`default_nettype none

module dfk_back
   import dfk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  geom_type   geom,
   input  link_type   q_link,
   output logic       q_ready,
   output result_type rsp_data,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   back_state_type            state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [1:0]                k_ff, k_in;

   logic signed [DIFF_W-1:0]  ab_ff [3], ab_in [3];
   logic signed [DIFF_W-1:0]  ac_ff [3], ac_in [3];
   logic signed [POS_W-1:0]   ha_ff, ha_in;
   logic signed [MUL_W-1:0]   u_ff [3], u_in [3];
   logic signed [MUL_W-1:0]   v_ff [3], v_in [3];
   logic signed [MUL_W-1:0]   w_ff [3], w_in [3];
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [VLEN_W-1:0]         vlen_ff, vlen_in;
   logic signed [PROJ_W-1:0]  proj_ff, proj_in;
   logic signed [ACC_W-1:0]   vsq_ff, vsq_in;
   logic signed [ACC_W-1:0]   yl_ff, yl_in;
   logic [ARM_W-1:0]          zl_ff, zl_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [POS_W-1:0]   res_ff [3], res_in [3];
   status_type                status_ff, status_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                out_ff, out_in;

   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [ACC_W-1:0]   acc_add, acc_sub;
   logic [POS_W-1:0]          xl;
   logic [1:0]                idx, idx_prev;
   logic [3:0]                slot_iss, slot_acc;
   logic                      sum_zero, zsq_neg, reach_fail, out_free;

   logic                      div_start, div_done;
   logic signed [ACC_W-1:0]   div_dividend, div_quot;
   logic [MUL_W-1:0]          div_divisor;
   logic                      sqrt_start, sqrt_done;
   logic [ACC_W-1:0]          sqrt_operand;
   logic [MUL_W-1:0]          sqrt_root;

   // output term schedule: {axis, term}, term 0 u*xl, 1 v*yl, 2 w*zl
   function automatic logic [3:0] res_slot(input logic [STEP_W-1:0] s);
      logic [3:0] r;
      r = 4'd0;
      case (s)
         4'd0: r = {2'd0, 2'd0};
         4'd1: r = {2'd0, 2'd1};
         4'd2: r = {2'd0, 2'd2};
         4'd3: r = {2'd1, 2'd0};
         4'd4: r = {2'd1, 2'd1};
         4'd5: r = {2'd1, 2'd2};
         4'd6: r = {2'd2, 2'd0};
         4'd7: r = {2'd2, 2'd1};
         4'd8: r = {2'd2, 2'd2};
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   assign xl         = POS_W'(dist_ff >> 1);
   assign idx        = step_ff[1:0];
   assign idx_prev   = step_ff[1:0] - 2'd1;
   assign slot_iss   = res_slot(step_ff);
   assign slot_acc   = res_slot(step_ff - 1'b1);
   assign acc_add    = acc_ff + prod_ff;
   assign acc_sub    = acc_ff - prod_ff;
   assign sum_zero   = (acc_add == '0);
   assign zsq_neg    = acc_sub[ACC_W-1];
   assign out_free   = !out_valid_ff || rsp_ready;
   assign reach_fail = ({1'b0, xl} > {2'b00, geom.arm})
                    || (yl_ff > $signed(ACC_W'(geom.arm)))
                    || (yl_ff < -$signed(ACC_W'(geom.arm)));
   assign q_ready    = (state_ff == BK_IDLE);

   dfk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   dfk_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         BK_DSQ: begin
            if (step_ff < 4'd3) begin
               mul_a = MUL_W'(ab_ff[idx]);
               mul_b = MUL_W'(ab_ff[idx]);
            end
         end
         BK_PROJ: begin
            if (step_ff < 4'd3) begin
               mul_a = u_ff[idx];
               mul_b = MUL_W'(ac_ff[idx]);
            end
         end
         BK_VRAW: begin
            if (step_ff < 4'd3) begin
               mul_a = u_ff[idx];
               mul_b = MUL_W'(proj_ff);
            end
         end
         BK_VSQ: begin
            if (step_ff < 4'd3) begin
               mul_a = v_ff[idx];
               mul_b = v_ff[idx];
            end
         end
         BK_CROSS: begin
            case (step_ff)
               4'd0: begin mul_a = u_ff[1]; mul_b = v_ff[2]; end
               4'd1: begin mul_a = u_ff[2]; mul_b = v_ff[1]; end
               4'd2: begin mul_a = u_ff[2]; mul_b = v_ff[0]; end
               4'd3: begin mul_a = u_ff[0]; mul_b = v_ff[2]; end
               4'd4: begin mul_a = u_ff[0]; mul_b = v_ff[1]; end
               4'd5: begin mul_a = u_ff[1]; mul_b = v_ff[0]; end
               default: ;
            endcase
         end
         BK_NUM: begin
            if (step_ff == 4'd0) begin
               mul_a = MUL_W'(proj_ff);
               mul_b = MUL_W'(proj_ff);
            end else if (step_ff == 4'd1) begin
               mul_a = MUL_W'(proj_ff);
               mul_b = $signed(MUL_W'(xl));
            end
         end
         BK_ZSQ: begin
            case (step_ff)
               4'd0: begin
                  mul_a = $signed(MUL_W'(geom.arm));
                  mul_b = $signed(MUL_W'(geom.arm));
               end
               4'd1: begin
                  mul_a = $signed(MUL_W'(xl));
                  mul_b = $signed(MUL_W'(xl));
               end
               4'd2: begin
                  mul_a = $signed(yl_ff[MUL_W-1:0]);
                  mul_b = $signed(yl_ff[MUL_W-1:0]);
               end
               default: ;
            endcase
         end
         BK_RES: begin
            if (step_ff < 4'd9) begin
               case (slot_iss[1:0])
                  2'd0: begin
                     mul_a = u_ff[slot_iss[3:2]];
                     mul_b = $signed(MUL_W'(xl));
                  end
                  2'd1: begin
                     mul_a = v_ff[slot_iss[3:2]];
                     mul_b = $signed(yl_ff[MUL_W-1:0]);
                  end
                  default: begin
                     mul_a = w_ff[slot_iss[3:2]];
                     mul_b = $signed(MUL_W'(zl_ff));
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_link.valid) begin
               state_in = BK_DSQ;
               step_in  = '0;
            end
         end
         BK_DSQ, BK_VSQ: begin
            if (step_ff != 4'd3) begin
               step_in = step_ff + 1'b1;
            end else if (sum_zero) begin
               state_in = BK_DONE;
            end else begin
               state_in = (state_ff == BK_DSQ) ? BK_SQ_DIST : BK_SQ_VLEN;
            end
         end
         BK_SQ_DIST, BK_SQ_VLEN: begin
            if (sqrt_done) begin
               state_in = (state_ff == BK_SQ_DIST) ? BK_UDIV : BK_VDIV;
               step_in  = '0;
               k_in     = '0;
            end
         end
         BK_UDIV, BK_VDIV: begin
            if (step_ff == '0) begin
               step_in = 4'd1;
            end else if (div_done) begin
               step_in = '0;
               if (k_ff == 2'd2) begin
                  state_in = (state_ff == BK_UDIV) ? BK_PROJ : BK_CROSS;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         BK_PROJ, BK_VRAW: begin
            if (step_ff != 4'd3) begin
               step_in = step_ff + 1'b1;
            end else begin
               state_in = (state_ff == BK_PROJ) ? BK_VRAW : BK_VSQ;
               step_in  = '0;
            end
         end
         BK_CROSS: begin
            if (step_ff != 4'd6) begin
               step_in = step_ff + 1'b1;
            end else begin
               state_in = BK_NUM;
               step_in  = '0;
            end
         end
         BK_NUM: begin
            if (step_ff != 4'd2) begin
               step_in = step_ff + 1'b1;
            end else begin
               state_in = BK_YDIV;
            end
         end
         BK_YDIV: begin
            if (div_done) begin
               state_in = BK_ZSQ;
               step_in  = '0;
            end
         end
         BK_ZSQ: begin
            if (step_ff == '0 && reach_fail) begin
               state_in = BK_DONE;
            end else if (step_ff != 4'd3) begin
               step_in = step_ff + 1'b1;
            end else begin
               state_in = zsq_neg ? BK_DONE : BK_SQ_Z;
            end
         end
         BK_SQ_Z: begin
            if (sqrt_done) begin
               state_in = BK_RES;
               step_in  = '0;
            end
         end
         BK_RES: begin
            if (step_ff != 4'd9) begin
               step_in = step_ff + 1'b1;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath updates and unit launches
   always_comb begin
      logic signed [ACC_W-1:0] total;
      ab_in        = ab_ff;
      ac_in        = ac_ff;
      ha_in        = ha_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      dist_in      = dist_ff;
      vlen_in      = vlen_ff;
      proj_in      = proj_ff;
      vsq_in       = vsq_ff;
      yl_in        = yl_ff;
      zl_in        = zl_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      sqrt_start   = 1'b0;
      sqrt_operand = '0;
      total        = '0;
      case (state_ff)
         BK_IDLE: begin
            if (q_link.valid) begin
               ab_in[0]  = q_link.item.ab_x;
               ab_in[1]  = q_link.item.ab_y;
               ab_in[2]  = q_link.item.ab_z;
               ac_in[0]  = q_link.item.ac_x;
               ac_in[1]  = q_link.item.ac_y;
               ac_in[2]  = q_link.item.ac_z;
               ha_in     = q_link.item.height_a;
               status_in = ST_OK;
               acc_in    = '0;
            end
         end
         BK_DSQ, BK_VSQ: begin
            if (step_ff != '0) begin
               acc_in = acc_add;
            end
            if (step_ff == 4'd3) begin
               if (sum_zero) begin
                  status_in = ST_DEGENERATE;
               end else begin
                  sqrt_start   = 1'b1;
                  sqrt_operand = unsigned'(acc_add);
                  if (state_ff == BK_VSQ) begin
                     vsq_in = acc_add;
                  end
               end
            end
         end
         BK_SQ_DIST: begin
            if (sqrt_done) begin
               dist_in = sqrt_root[DIST_W-1:0];
            end
         end
         BK_SQ_VLEN: begin
            if (sqrt_done) begin
               vlen_in = sqrt_root[VLEN_W-1:0];
            end
         end
         BK_UDIV: begin
            if (step_ff == '0) begin
               div_start    = 1'b1;
               div_dividend = ACC_W'(ab_ff[k_ff]) <<< UNIT_BITS;
               div_divisor  = MUL_W'(dist_ff);
            end else if (div_done) begin
               u_in[k_ff] = div_quot[MUL_W-1:0];
               acc_in     = '0;
            end
         end
         BK_VDIV: begin
            if (step_ff == '0) begin
               div_start    = 1'b1;
               div_dividend = ACC_W'(v_ff[k_ff]) <<< UNIT_BITS;
               div_divisor  = MUL_W'(vlen_ff);
            end else if (div_done) begin
               v_in[k_ff] = div_quot[MUL_W-1:0];
            end
         end
         BK_PROJ: begin
            if (step_ff != '0) begin
               acc_in = acc_add;
            end
            if (step_ff == 4'd3) begin
               total   = rnd_unit(acc_add);
               proj_in = total[PROJ_W-1:0];
            end
         end
         BK_VRAW: begin
            if (step_ff != '0) begin
               total          = ACC_W'(ac_ff[idx_prev]) - rnd_unit(prod_ff);
               v_in[idx_prev] = total[MUL_W-1:0];
            end
            if (step_ff == 4'd3) begin
               acc_in = '0;
            end
         end
         BK_CROSS: begin
            if (step_ff[0]) begin
               acc_in = prod_ff;
            end else if (step_ff != '0) begin
               total                       = rnd_unit(acc_sub);
               w_in[step_ff[2:1] - 2'd1]   = total[MUL_W-1:0];
            end
         end
         BK_NUM: begin
            if (step_ff == 4'd1) begin
               acc_in = vsq_ff + prod_ff;
            end else if (step_ff == 4'd2) begin
               div_start    = 1'b1;
               div_dividend = acc_ff - (prod_ff <<< 1);
               div_divisor  = MUL_W'({vlen_ff, 1'b0});
            end
         end
         BK_YDIV: begin
            if (div_done) begin
               yl_in = div_quot;
            end
         end
         BK_ZSQ: begin
            case (step_ff)
               4'd0: begin
                  if (reach_fail) begin
                     status_in = ST_UNREACHABLE;
                  end
               end
               4'd1: acc_in = prod_ff;
               4'd2: acc_in = acc_sub;
               default: begin
                  if (zsq_neg) begin
                     status_in = ST_UNREACHABLE;
                  end else begin
                     sqrt_start   = 1'b1;
                     sqrt_operand = unsigned'(acc_sub);
                  end
               end
            endcase
         end
         BK_SQ_Z: begin
            if (sqrt_done) begin
               zl_in = sqrt_root[ARM_W-1:0];
            end
         end
         BK_RES: begin
            if (step_ff != '0) begin
               case (slot_acc[1:0])
                  2'd0: acc_in = prod_ff;
                  2'd1: acc_in = acc_add;
                  default: begin
                     case (slot_acc[3:2])
                        2'd0:    total = ACC_W'(geom.a_x);
                        2'd1:    total = ACC_W'(geom.a_y);
                        default: total = ACC_W'(ha_ff);
                     endcase
                     total = total + rnd_unit(acc_sub);
                     if (total > POS_MAX) begin
                        total = POS_MAX;
                     end else if (total < POS_MIN) begin
                        total = POS_MIN;
                     end
                     res_in[slot_acc[3:2]] = total[POS_W-1:0];
                  end
               endcase
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_in.status = status_ff;
               if (status_ff == ST_OK) begin
                  out_in.x = res_ff[0];
                  out_in.y = res_ff[1];
                  out_in.z = res_ff[2];
               end else begin
                  out_in.x = '0;
                  out_in.y = '0;
                  out_in.z = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ab_ff     <= ab_in;
      ac_ff     <= ac_in;
      ha_ff     <= ha_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      dist_ff   <= dist_in;
      vlen_ff   <= vlen_in;
      proj_ff   <= proj_in;
      vsq_ff    <= vsq_in;
      yl_ff     <= yl_in;
      zl_ff     <= zl_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE && out_free) |=> (out_valid_ff && state_ff == BK_IDLE))
      else $error("finished item not moved to the output register");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != ST_OK)
         |-> (out_ff.x == '0 && out_ff.y == '0 && out_ff.z == '0))
      else $error("failed solve carries a nonzero position");

   a_sqrt_owner: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == BK_SQ_DIST || state_ff == BK_SQ_VLEN
                     || state_ff == BK_SQ_Z))
      else $error("root result arrived with no sequencer waiting");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == BK_UDIV || state_ff == BK_VDIV || state_ff == BK_YDIV))
      else $error("quotient arrived with no sequencer waiting");

endmodule

`default_nettype wire

@@ design/delta_forward_kinematics.sv @@
// Top level: register port, stream ports, front end and trilateration back end.
//
//  port group  direction  contents
//  req_*       in         tdata: carriage_a, carriage_b, carriage_c (27 b each)
//  rsp_*       out        tdata: effector_x, effector_y, effector_z; tuser: solve_status
//  csr_*       in/out     towers A..C x/y and arm_length at byte offsets 0..24
//
// In the back end, an item that solves uses seven divisions on the shared
// one-bit-per-cycle divider, three roots, and the multiply steps on the single
// multiplier. A degenerate item finishes after the first or second length check.
// The front queue holds four items and, while it has room, keeps accepting while the
// back end works and while a result waits in the output register. Reset is synchronous
// and clears the registers, the queue and the sequencer.
`default_nettype none

module delta_forward_kinematics
   import dfk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // carriage_a, carriage_b, carriage_c, pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // effector_x, effector_y, effector_z, pad
   output logic [1:0]             rsp_tuser,   // solve_status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   geom_type      geom_ff, geom_in;
   reg_index_type csr_index;
   logic          csr_write;
   link_type      q_link;
   logic          q_ready;
   result_type    rsp_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_AW-1:2]);

   always_comb begin
      geom_in = geom_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_TOWER_A_X:  geom_in.a_x = csr_pwdata[POS_W-1:0];
            REG_TOWER_A_Y:  geom_in.a_y = csr_pwdata[POS_W-1:0];
            REG_TOWER_B_X:  geom_in.b_x = csr_pwdata[POS_W-1:0];
            REG_TOWER_B_Y:  geom_in.b_y = csr_pwdata[POS_W-1:0];
            REG_TOWER_C_X:  geom_in.c_x = csr_pwdata[POS_W-1:0];
            REG_TOWER_C_Y:  geom_in.c_y = csr_pwdata[POS_W-1:0];
            REG_ARM_LENGTH: geom_in.arm = csr_pwdata[ARM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TOWER_A_X:  csr_prdata = CSR_DW'($unsigned(geom_ff.a_x));
         REG_TOWER_A_Y:  csr_prdata = CSR_DW'($unsigned(geom_ff.a_y));
         REG_TOWER_B_X:  csr_prdata = CSR_DW'($unsigned(geom_ff.b_x));
         REG_TOWER_B_Y:  csr_prdata = CSR_DW'($unsigned(geom_ff.b_y));
         REG_TOWER_C_X:  csr_prdata = CSR_DW'($unsigned(geom_ff.c_x));
         REG_TOWER_C_Y:  csr_prdata = CSR_DW'($unsigned(geom_ff.c_y));
         REG_ARM_LENGTH: csr_prdata = CSR_DW'(geom_ff.arm);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '0;
      end else begin
         geom_ff <= geom_in;
      end
   end

   dfk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .carriage_a (req_tdata[POS_W-1:0]),
      .carriage_b (req_tdata[2*POS_W-1:POS_W]),
      .carriage_c (req_tdata[3*POS_W-1:2*POS_W]),
      .q_link     (q_link),
      .q_ready    (q_ready)
   );

   dfk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom_ff),
      .q_link    (q_link),
      .q_ready   (q_ready),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - 3 * POS_W){1'b0}}, rsp_data.z, rsp_data.y, rsp_data.x};
   assign rsp_tuser = rsp_data.status;

endmodule

`default_nettype wire
